@@ rtl/cssv_pkg.sv @@
// types, codes and constants shared by the cosine similarity vector store
`default_nettype none
package cssv_pkg;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_QUERY = 2'd1,
        ACT_SCORE = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        STS_OK     = 2'd0,
        STS_RANGE  = 2'd1,
        STS_ZERO   = 2'd2,
        STS_WRANGE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_ROW_COUNT = 2'd0,
        CFG_ROW_CAP   = 2'd1,
        CFG_VEC_LEN   = 2'd2,
        CFG_UNUSED    = 2'd3
    } t_cfg_index;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ELEM, S_ACC, S_SQRT, S_NORM, S_RNORM, S_CHECK,
        S_DOT_RD, S_DOT_MUL, S_DOT_ACC, S_DEN, S_DIV_INIT, S_DIV, S_SCORE, S_EMIT
    } t_state;

    typedef struct packed {
        logic [1:0]         action;
        logic [15:0]        row_sel;
        logic signed [15:0] element;
        logic               end_of_batch;
    } t_in_item;

    typedef struct packed {
        logic signed [17:0] score;
        logic [18:0]        norm_val;
        logic [1:0]         status;
        logic               batch_end;
    } t_out_item;

    localparam logic [39:0]        SUM_MAX        = 40'hFF_FFFF_FFFF;
    localparam logic [18:0]        NORM_MAX       = 19'h7FFFF;
    localparam logic signed [17:0] SCORE_SENTINEL = -18'sd131072;
    localparam logic [16:0]        SCORE_ONE      = 17'd65536;
    localparam logic [39:0]        SQRT_BIT_INIT  = 40'h40_0000_0000;
    localparam logic [10:0]        CAP_RESET      = 11'd1024;
    localparam logic [7:0]         VLEN_RESET     = 8'd128;

endpackage
`default_nettype wire

@@ rtl/cosine_similarity_vector_store.sv @@
// cosine similarity vector store: row store, norms, query buffer and scoring sequencer
//
// Input channel i_in (valid/stall) carries one request transaction: write one row
// element, load one query element, or score one stored row. Output channel o_out
// (valid/stall) returns at most one result per request: the row norm after the last
// element of a row write, or the score of a scored row. Configuration writes use
// i_cfg_valid/o_cfg_ready with a register index and data, and are taken at any time.
// Steps: a non-final element is squared and accumulated; the final element then goes
// on through the bit-pair square root. A score runs each element through the one
// shared multiplier, then the bit-serial divider (one quotient bit per cycle).
// One request is in work at a time; o_in_stall is high until it is finished and its
// result is in the output register. A finished result waits in the output register
// while i_out_stall is high; the next request is taken meanwhile, and its result
// waits for the register. After reset the norm store is swept to zero, one row per
// cycle, over all ROWS rows, with o_in_stall high.
`default_nettype none
module cosine_similarity_vector_store #(
    parameter int ROWS    = 1024,
    parameter int DIM_MAX = 128
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    input  cssv_pkg::t_in_item      i_in,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    output cssv_pkg::t_out_item     o_out,
    input  wire                     i_out_stall,
    input  wire                     i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire [1:0]               i_cfg_index,
    input  wire [10:0]              i_cfg_data
);
    import cssv_pkg::*;

    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int PW   = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
    localparam int LW   = $clog2(DIM_MAX + 1);
    localparam int AW   = (ROWS * DIM_MAX > 1) ? $clog2(ROWS * DIM_MAX) : 1;
    localparam int DW   = 32 + $clog2(DIM_MAX + 1);
    localparam int NW   = DW + 16;
    localparam int CNTW = ($clog2(NW + 1) > LW) ? $clog2(NW + 1) : LW;

    logic signed [15:0] vec_mem [ROWS * DIM_MAX];
    logic signed [15:0] q_mem [DIM_MAX];
    logic [18:0]        norm_mem [ROWS];

    t_state             r_state, n_state;
    t_action            r_act, n_act;
    logic [15:0]        r_row, n_row;
    logic signed [15:0] r_elem, n_elem;
    logic               r_eob, n_eob;
    logic [PW-1:0]      r_pos, n_pos;
    logic [39:0]        r_sum, n_sum;
    logic [18:0]        r_qnorm, n_qnorm;
    logic [CNTW-1:0]    r_cnt, n_cnt;
    logic signed [39:0] r_prod, n_prod;
    logic signed [DW-1:0] r_dot, n_dot;
    logic [39:0]        r_sv, n_sv;
    logic [39:0]        r_res, n_res;
    logic [39:0]        r_bit, n_bit;
    logic [38:0]        r_rem, n_rem;
    logic [NW-1:0]      r_quo, n_quo;
    logic [18:0]        r_rn, n_rn;
    logic               r_neg, n_neg;
    logic signed [17:0] r_score, n_score;
    logic [18:0]        r_norm, n_norm;
    logic [1:0]         r_status, n_status;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;
    logic [RW-1:0]      r_clr, n_clr;
    logic [10:0]        r_rcount, r_cap;
    logic [7:0]         r_vlen;
    logic signed [15:0] r_vrd, r_qrd;
    logic [18:0]        r_nrd;

    logic [LW-1:0]      len_eff;
    logic [16:0]        cap_eff, cnt_eff;
    logic               last, in_cap, in_range, out_free;
    logic [40:0]        sum_wide;
    logic [39:0]        sum_sat;
    logic [40:0]        sqrt_try;
    logic [38:0]        div_try;
    logic               div_ge;
    logic [DW-1:0]      dot_mag;
    logic [16:0]        score_mag;
    logic [18:0]        norm_sat;
    logic signed [19:0] mul_a, mul_b;
    logic [AW-1:0]      vaddr;
    logic [PW-1:0]      qaddr;
    logic               vec_we, q_we, norm_we;
    logic [RW-1:0]      norm_waddr;
    logic [18:0]        norm_wdata;

    // effective configuration
    always_comb begin
        if (r_vlen == 8'd0) begin
            len_eff = LW'(1);
        end else if (11'(r_vlen) > 11'(DIM_MAX)) begin
            len_eff = LW'(DIM_MAX);
        end else begin
            len_eff = LW'(r_vlen);
        end
        cap_eff  = (17'(r_cap) < 17'(ROWS)) ? 17'(r_cap) : 17'(ROWS);
        cnt_eff  = (17'(r_rcount) < 17'(ROWS)) ? 17'(r_rcount) : 17'(ROWS);
        last     = (LW'(r_pos) + LW'(1)) >= len_eff;
        in_cap   = 17'(r_row) < cap_eff;
        in_range = 17'(r_row) < cnt_eff;
        out_free = !r_out_valid || !i_out_stall;
        sum_wide = 41'(r_sum) + 41'(r_prod[31:0]);
        sum_sat  = (sum_wide > 41'(SUM_MAX)) ? SUM_MAX : sum_wide[39:0];
        sqrt_try = 41'(r_res) + 41'(r_bit);
        div_try  = {r_rem[37:0], r_quo[NW-1]};
        div_ge   = div_try >= {1'b0, r_prod[37:0]};
        dot_mag  = r_dot[DW-1] ? DW'(-r_dot) : DW'(r_dot);
        score_mag = (r_quo > NW'(SCORE_ONE)) ? SCORE_ONE : r_quo[16:0];
        norm_sat = (r_res > 40'(NORM_MAX)) ? NORM_MAX : r_res[18:0];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:    if (r_clr == RW'(ROWS - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (i_in_valid) begin
                    case (t_action'(i_in.action))
                        ACT_WRITE, ACT_QUERY: n_state = S_ELEM;
                        ACT_SCORE:            n_state = S_RNORM;
                        default:              n_state = S_IDLE;
                    endcase
                end
            end
            S_ELEM:     n_state = S_ACC;
            S_ACC:      n_state = last ? S_SQRT : S_IDLE;
            S_SQRT:     if (r_bit == 40'd0) n_state = S_NORM;
            S_NORM:     n_state = (r_act == ACT_QUERY) ? S_IDLE : S_EMIT;
            S_RNORM:    n_state = S_CHECK;
            S_CHECK: begin
                if (r_qnorm == 19'd0 || !in_range || r_nrd == 19'd0) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_DOT_RD;
                end
            end
            S_DOT_RD:   n_state = S_DOT_MUL;
            S_DOT_MUL:  n_state = S_DOT_ACC;
            S_DOT_ACC:  n_state = (r_cnt + CNTW'(1) == CNTW'(len_eff)) ? S_DEN : S_DOT_RD;
            S_DEN:      n_state = S_DIV_INIT;
            S_DIV_INIT: n_state = S_DIV;
            S_DIV:      if (r_cnt == CNTW'(1)) n_state = S_SCORE;
            S_SCORE:    n_state = S_EMIT;
            S_EMIT:     if (out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        n_act = r_act;  n_row = r_row;  n_elem = r_elem;  n_eob = r_eob;
        n_pos = r_pos;  n_sum = r_sum;  n_qnorm = r_qnorm;  n_cnt = r_cnt;
        n_prod = r_prod;  n_dot = r_dot;  n_sv = r_sv;  n_res = r_res;
        n_bit = r_bit;  n_rem = r_rem;  n_quo = r_quo;  n_rn = r_rn;
        n_neg = r_neg;  n_score = r_score;  n_norm = r_norm;  n_status = r_status;
        n_out = r_out;  n_clr = r_clr;
        n_out_valid = r_out_valid && i_out_stall;
        mul_a = 20'(r_elem);
        mul_b = 20'(r_elem);
        case (r_state)
            S_CLEAR: n_clr = r_clr + RW'(1);
            S_IDLE: begin
                n_act  = t_action'(i_in.action);
                n_row  = i_in.row_sel;
                n_elem = i_in.element;
                n_eob  = i_in.end_of_batch;
            end
            S_ELEM:  n_prod = mul_a * mul_b;
            S_ACC: begin
                if (last) begin
                    n_pos = '0;
                    n_sum = '0;
                    n_sv  = sum_sat;
                    n_res = '0;
                    n_bit = SQRT_BIT_INIT;
                end else begin
                    n_pos = r_pos + PW'(1);
                    n_sum = sum_sat;
                end
            end
            S_SQRT: begin
                if (r_bit != 40'd0) begin
                    if (41'(r_sv) >= sqrt_try) begin
                        n_sv  = r_sv - sqrt_try[39:0];
                        n_res = (r_res >> 1) + r_bit;
                    end else begin
                        n_res = r_res >> 1;
                    end
                    n_bit = r_bit >> 2;
                end
            end
            S_NORM: begin
                n_score = '0;
                if (r_act == ACT_QUERY) begin
                    n_qnorm = norm_sat;
                end else if (in_cap) begin
                    n_norm   = norm_sat;
                    n_status = STS_OK;
                end else begin
                    n_norm   = '0;
                    n_status = STS_WRANGE;
                end
            end
            S_CHECK: begin
                n_rn  = in_range ? r_nrd : 19'd0;
                n_cnt = '0;
                n_dot = '0;
                n_score = '0;
                n_norm  = '0;
                n_status = STS_ZERO;
                if (r_qnorm == 19'd0) begin
                    n_norm = in_range ? r_nrd : 19'd0;
                end else if (!in_range) begin
                    n_score  = SCORE_SENTINEL;
                    n_status = STS_RANGE;
                end
            end
            S_DOT_MUL: begin
                mul_a  = 20'(r_vrd);
                mul_b  = 20'(r_qrd);
                n_prod = mul_a * mul_b;
            end
            S_DOT_ACC: begin
                n_dot = r_dot + DW'($signed(r_prod[31:0]));
                n_cnt = r_cnt + CNTW'(1);
            end
            S_DEN: begin
                mul_a  = {1'b0, r_rn};
                mul_b  = {1'b0, r_qnorm};
                n_prod = mul_a * mul_b;
            end
            S_DIV_INIT: begin
                n_neg = r_dot[DW-1];
                n_quo = {dot_mag, 16'd0};
                n_rem = '0;
                n_cnt = CNTW'(NW);
            end
            S_DIV: begin
                n_rem = div_ge ? div_try - {1'b0, r_prod[37:0]} : div_try;
                n_quo = {r_quo[NW-2:0], div_ge};
                n_cnt = r_cnt - CNTW'(1);
            end
            S_SCORE: begin
                n_score  = r_neg ? -$signed({1'b0, score_mag}) : $signed({1'b0, score_mag});
                n_norm   = r_rn;
                n_status = STS_OK;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.score     = r_score;
                    n_out.norm_val  = r_norm;
                    n_out.status    = r_status;
                    n_out.batch_end = r_eob;
                end
            end
            default: ;
        endcase
    end

    // outputs and memory controls
    always_comb begin
        o_in_stall  = (r_state != S_IDLE);
        o_out_valid = r_out_valid;
        o_out       = r_out;
        o_cfg_ready = 1'b1;
        vaddr = AW'(r_row[RW-1:0]) * AW'(DIM_MAX)
              + AW'((r_state == S_ELEM) ? r_pos : r_cnt[PW-1:0]);
        qaddr = (r_state == S_ELEM) ? r_pos : r_cnt[PW-1:0];
        vec_we = (r_state == S_ELEM) && (r_act == ACT_WRITE) && in_cap;
        q_we   = (r_state == S_ELEM) && (r_act == ACT_QUERY);
        norm_we = (r_state == S_CLEAR)
               || ((r_state == S_NORM) && (r_act == ACT_WRITE) && in_cap);
        norm_waddr = (r_state == S_CLEAR) ? r_clr : r_row[RW-1:0];
        norm_wdata = (r_state == S_CLEAR) ? 19'd0 : norm_sat;
    end

    always_ff @(posedge i_clk) begin
        if (vec_we) begin
            vec_mem[vaddr] <= r_elem;
        end
        r_vrd <= vec_mem[vaddr];
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            q_mem[qaddr] <= r_elem;
        end
        r_qrd <= q_mem[qaddr];
    end

    always_ff @(posedge i_clk) begin
        if (norm_we) begin
            norm_mem[norm_waddr] <= norm_wdata;
        end
        r_nrd <= norm_mem[r_row[RW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_pos       <= '0;
            r_sum       <= '0;
            r_qnorm     <= '0;
            r_out_valid <= 1'b0;
            r_rcount    <= '0;
            r_cap       <= CAP_RESET;
            r_vlen      <= VLEN_RESET;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_pos       <= n_pos;
            r_sum       <= n_sum;
            r_qnorm     <= n_qnorm;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_ROW_COUNT: r_rcount <= i_cfg_data;
                    CFG_ROW_CAP:   r_cap    <= i_cfg_data;
                    CFG_VEC_LEN:   r_vlen   <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_act <= n_act;  r_row <= n_row;  r_elem <= n_elem;  r_eob <= n_eob;
        r_cnt <= n_cnt;  r_prod <= n_prod;  r_dot <= n_dot;  r_sv <= n_sv;
        r_res <= n_res;  r_bit <= n_bit;  r_rem <= n_rem;  r_quo <= n_quo;
        r_rn <= n_rn;  r_neg <= n_neg;  r_score <= n_score;  r_norm <= n_norm;
        r_status <= n_status;  r_out <= n_out;
    end

    a_sentinel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == STS_RANGE) |->
            (r_out.score == SCORE_SENTINEL && r_out.norm_val == 19'd0))
        else $error("range status without sentinel score");

    a_zero_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status == STS_ZERO || r_out.status == STS_WRANGE)) |->
            (r_out.score == 18'sd0))
        else $error("nonzero score with zero norm or write status");

    a_wrange_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == STS_WRANGE) |-> (r_out.norm_val == 19'd0))
        else $error("norm given for a write beyond capacity");

    a_score_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == STS_OK) |->
            (r_out.score <= 18'sd65536 && r_out.score >= -18'sd65536))
        else $error("score beyond unity");

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR || r_state == S_DIV || r_state == S_SQRT) |-> o_in_stall)
        else $error("request taken while busy");

endmodule
`default_nettype wire

@@ dv/cosine_similarity_vector_store_tb.sv @@
// testbench for the cosine similarity vector store: random and directed requests, scoreboard
`timescale 1ns / 100ps
`default_nettype none
module cosine_similarity_vector_store_tb;
    import cssv_pkg::*;

    localparam int ROWS = 1024;
    localparam int DIM_MAX = 128;
    localparam longint CYCLE_LIMIT = 64'd3_000_000;

    class cosine_scoreboard;
        logic signed [15:0] row_elems [ROWS*DIM_MAX];
        logic [18:0] norm_tab [ROWS];
        logic signed [15:0] query_elems [DIM_MAX];
        logic [18:0] q_norm;
        int unsigned elem_pos;
        logic [39:0] sq_sum;
        int unsigned cnt_rows, cap_rows, vlen;
        t_out_item pending [$];
        int errors;

        function new();
            foreach (norm_tab[i]) norm_tab[i] = '0;
            foreach (row_elems[i]) row_elems[i] = '0;
            foreach (query_elems[i]) query_elems[i] = '0;
            q_norm = '0; elem_pos = 0; sq_sum = '0;
            cnt_rows = 0; cap_rows = 1024; vlen = 128; errors = 0;
        endfunction

        function void write_reg(t_cfg_index idx, logic [10:0] val);
            case (idx)
                CFG_ROW_COUNT: cnt_rows = val;
                CFG_ROW_CAP:   cap_rows = val;
                CFG_VEC_LEN:   vlen = val[7:0];
                default: ;
            endcase
        endfunction

        function logic [18:0] floor_sqrt(logic [39:0] v);
            logic [63:0] r, b, x;
            x = v; r = 0; b = 64'h4000_0000_0000_0000;
            while (b > x) b = b >> 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return (r > NORM_MAX) ? NORM_MAX : r[18:0];
        endfunction

        function void note_request(t_in_item it);
            int unsigned len, p, row;
            bit last, in_cap, in_rng;
            logic [63:0] s;
            logic [18:0] nrm, rn;
            longint dot, mag, den;
            t_out_item r;
            len = (vlen == 0) ? 1 : (vlen > DIM_MAX ? DIM_MAX : vlen);
            row = it.row_sel;
            r = '0;
            r.batch_end = it.end_of_batch;
            if (it.action == ACT_WRITE || it.action == ACT_QUERY) begin
                p = elem_pos;
                last = (p + 1 >= len);
                in_cap = row < ((cap_rows < ROWS) ? cap_rows : ROWS);
                if (it.action == ACT_WRITE) begin
                    if (in_cap) row_elems[row*DIM_MAX + p] = it.element;
                end else begin
                    query_elems[p] = it.element;
                end
                s = {24'd0, sq_sum} + 64'(longint'(it.element) * longint'(it.element));
                sq_sum = (s > {24'd0, SUM_MAX}) ? SUM_MAX : s[39:0];
                if (!last) begin
                    elem_pos = p + 1;
                    return;
                end
                nrm = floor_sqrt(sq_sum);
                elem_pos = 0; sq_sum = '0;
                if (it.action == ACT_QUERY) begin
                    q_norm = nrm;
                    return;
                end
                if (in_cap) begin
                    norm_tab[row] = nrm;
                    r.norm_val = nrm;
                    r.status = STS_OK;
                end else begin
                    r.status = STS_WRANGE;
                end
            end else if (it.action == ACT_SCORE) begin
                len = (vlen == 0) ? 1 : (vlen > DIM_MAX ? DIM_MAX : vlen);
                in_rng = row < ((cnt_rows < ROWS) ? cnt_rows : ROWS);
                rn = in_rng ? norm_tab[row] : '0;
                if (q_norm == 0) begin
                    r.norm_val = rn; r.status = STS_ZERO;
                end else if (!in_rng) begin
                    r.score = SCORE_SENTINEL; r.status = STS_RANGE;
                end else if (rn == 0) begin
                    r.status = STS_ZERO;
                end else begin
                    dot = 0;
                    for (int i = 0; i < len; i++)
                        dot += longint'(row_elems[row*DIM_MAX + i]) * longint'(query_elems[i]);
                    den = longint'(rn) * longint'(q_norm);
                    mag = (dot < 0) ? -dot : dot;
                    mag = (mag <<< 16) / den;
                    if (mag > 65536) mag = 65536;
                    r.score = 18'((dot < 0) ? -mag : mag);
                    r.norm_val = rn; r.status = STS_OK;
                end
            end else begin
                return;
            end
            pending.push_back(r);
        endfunction

        function void check_result(t_out_item got);
            t_out_item e;
            if (pending.size() == 0) begin
                $error("unexpected result transaction %p", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.score !== e.score) begin
                $error("score expected %0d actual %0d", e.score, got.score); errors++;
            end
            if (got.norm_val !== e.norm_val) begin
                $error("norm_val expected %0d actual %0d", e.norm_val, got.norm_val); errors++;
            end
            if (got.status !== e.status) begin
                $error("status expected %0d actual %0d", e.status, got.status); errors++;
            end
            if (got.batch_end !== e.batch_end) begin
                $error("batch_end expected %0d actual %0d", e.batch_end, got.batch_end);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    t_in_item i_in = '0;
    logic o_in_stall, o_out_valid, o_cfg_ready;
    t_out_item o_out;
    logic i_out_stall = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [1:0] i_cfg_index = '0;
    logic [10:0] i_cfg_data = '0;

    cosine_scoreboard sb;
    longint cycles = 0;
    int stall_mode = 0;
    // row lengths in use: rows are always fully written before scoring
    int unsigned cur_len = 128, cur_cnt = 0, cur_cap = 1024;
    bit row_written [ROWS];
    bit query_loaded = 0;
    int sent = 0;
    int burst_left = 0;

    always #10 i_clk = ~i_clk;

    cosine_similarity_vector_store dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in(i_in), .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid), .o_out(o_out), .i_out_stall(i_out_stall),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("cosine_similarity_vector_store: mismatch");
            $finish;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out);
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (($urandom_range(0, 199)) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= ($urandom_range(0, 1) == 0);
            default: i_out_stall <= ($urandom_range(0, 9) != 0);
        endcase
    end

    task automatic send_item(t_action act, logic [15:0] row, logic signed [15:0] el);
        t_in_item it;
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        it.action = act;
        it.row_sel = row;
        it.element = el;
        it.end_of_batch = 1'($urandom_range(0, 1));
        i_in <= it;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_request(it);
        sent++;
        @(negedge i_clk);
        if (burst_left == 0) i_in_valid <= 1'b0;
    endtask

    function automatic logic signed [15:0] rand_elem();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return -16'sh8000;
            2: return 16'sd0;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic drain();
        if (burst_left != 0) begin
            i_in_valid <= 1'b0;
            burst_left = 0;
        end
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (600) @(negedge i_clk);
    endtask

    task automatic set_reg(t_cfg_index idx, logic [10:0] val);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // length change invalidates earlier rows for scoring
    task automatic new_setting(int unsigned cnt, int unsigned cap, int unsigned len);
        drain();
        set_reg(CFG_ROW_COUNT, 11'(cnt));
        set_reg(CFG_ROW_CAP, 11'(cap));
        set_reg(CFG_VEC_LEN, 11'(len));
        if (((len == 0) ? 1 : len) != cur_len) begin
            foreach (row_written[i]) row_written[i] = 0;
            query_loaded = 0;
        end
        cur_len = (len == 0) ? 1 : (len > DIM_MAX ? DIM_MAX : len);
        cur_cnt = cnt; cur_cap = cap;
    endtask

    task automatic write_row(logic [15:0] row, int kind);
        for (int i = 0; i < cur_len; i++)
            send_item(ACT_WRITE, row, kind == 1 ? 16'sh7FFF : kind == 2 ? -16'sh8000 :
                      kind == 3 ? 16'sd0 : rand_elem());
        if (row < cur_cap && row < ROWS) row_written[row] = 1;
    endtask

    task automatic load_query(int kind);
        for (int i = 0; i < cur_len; i++)
            send_item(ACT_QUERY, 16'($urandom()), kind == 3 ? 16'sd0 : rand_elem());
        query_loaded = 1;
    endtask

    // score only rows that are fully written, unwritten-norm rows, or out of range
    task automatic score_row(logic [15:0] row);
        bit ok;
        ok = !(row < cur_cnt && row < ROWS) || !(row < cur_cap) || row_written[row]
             || !query_loaded;
        if (!ok && query_loaded && sb.norm_tab[row] != 0) return;
        if (query_loaded && row < cur_cnt && row < ROWS && sb.norm_tab[row] != 0
            && !row_written[row]) return;
        send_item(ACT_SCORE, row, 16'($urandom()));
    endtask

    function automatic logic [15:0] pick_row();
        case ($urandom_range(0, 9))
            0: return 16'($urandom());
            1: return 16'(cur_cnt);
            2: return 16'(ROWS - 1);
            default: return 16'($urandom_range(0, 15));
        endcase
    endfunction

    initial begin
        sb = new();
        foreach (row_written[i]) row_written[i] = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: zero query norm, extremes, out of range and unused action
        score_row(16'd0);
        new_setting(1024, 1024, 2);
        write_row(16'd0, 1);
        write_row(16'd1, 2);
        write_row(16'd2, 3);
        write_row(16'd1023, 0);
        write_row(16'd5000, 0);
        send_item(ACT_NONE, 16'hFFFF, -16'sh1);
        score_row(16'd0);
        load_query(0);
        score_row(16'd0); score_row(16'd1); score_row(16'd2);
        score_row(16'd3); score_row(16'd1024); score_row(16'hFFFF);
        load_query(3);
        score_row(16'd0);
        new_setting(0, 0, 0);
        write_row(16'd0, 1);
        load_query(0);
        score_row(16'd0);

        for (int ph = 0; sent < 1950; ph++) begin
            case (ph % 5)
                0: new_setting($urandom_range(0, 2047), $urandom_range(0, 2047),
                               $urandom_range(0, 8));
                1: new_setting(1024, 1024, 128);
                2: new_setting(16, 12, $urandom_range(1, 16));
                3: new_setting(2047, 2047, 255);
                default: new_setting($urandom_range(0, 20), $urandom_range(0, 20),
                                     $urandom_range(1, 4));
            endcase
            for (int k = 0; k < 40 && sent < 1950; k++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: write_row(pick_row(), $urandom_range(0, 8));
                    3: load_query($urandom_range(0, 6));
                    4: send_item(ACT_NONE, 16'($urandom()), 16'($urandom()));
                    default: if (query_loaded) score_row(pick_row());
                             else load_query(0);
                endcase
                if (cur_len == 128 && k > 6) break;
            end
        end

        drain();
        if (sb.errors == 0)
            $display("cosine_similarity_vector_store: match");
        else
            $display("cosine_similarity_vector_store: mismatch");
        $finish;
    end

endmodule
`default_nettype wire
